### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HCBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcbp assertion failed");

// next-cycle implication, checked outside reset
`define HCBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcbp assertion failed");

`endif

### sv/hcbp_pkg.sv
`default_nettype none

package hcbp_pkg;

  localparam int unsigned CODE_W = 32;
  localparam int unsigned LEN_W = 6;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PEND_W = 7;
  localparam int unsigned PCNT_W = 3;
  localparam int unsigned ACC_W = PEND_W + CODE_W;
  localparam int unsigned QCNT_W = 3;
  localparam int unsigned TABLE_DEPTH = 256;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  localparam logic [BYTE_W-1:0] ASCII_EIGHT = 8'h38;
  localparam logic [QCNT_W-1:0] FLUSH_BYTES = 3'd2;

  typedef struct packed {
    logic valid;
    logic flush;
  } hcbp_s1_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } hcbp_entry_t;

endpackage

`default_nettype wire

### sv/hcbp_ram.sv
`default_nettype none

module hcbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]              rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### sv/hcbp_pack.sv
`default_nettype none

module hcbp_pack (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hcbp_pkg::hcbp_s1_t            s1,
  input  wire hcbp_pkg::hcbp_entry_t         entry,
  output logic                               s1_go,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]        out_byte,
  output logic                               out_last
);

  import hcbp_pkg::*;

  logic [PEND_W-1:0] pend_bits_r, pend_bits_nxt;
  logic [PCNT_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic [CODE_W-1:0] q_data_r, q_data_nxt;
  logic [QCNT_W-1:0] q_cnt_r, q_cnt_nxt;

  logic [ACC_W-1:0]  acc;
  logic [LEN_W-1:0]  total;
  logic [QCNT_W-1:0] nbytes;
  logic [PEND_W-1:0] pend_after;
  logic [QCNT_W-1:0] emit_cnt;
  logic [CODE_W-1:0] emit_data;
  logic              q_free;
  logic              q_pop;

  always_comb begin
    acc = ACC_W'(pend_bits_r) | (ACC_W'(entry.code) << pend_cnt_r);
    total = LEN_W'(pend_cnt_r) + entry.len;
    nbytes = total[LEN_W-1:3];
    unique case (nbytes)
      3'd0:    pend_after = acc[6:0];
      3'd1:    pend_after = acc[14:8];
      3'd2:    pend_after = acc[22:16];
      3'd3:    pend_after = acc[30:24];
      3'd4:    pend_after = acc[38:32];
      default: pend_after = acc[6:0];
    endcase
  end

  // flush: padded remainder byte, then trailer
  always_comb begin
    if (s1.flush) begin
      emit_cnt = FLUSH_BYTES;
      emit_data = {16'd0, ASCII_EIGHT - BYTE_W'(pend_cnt_r), 1'b0, pend_bits_r};
    end else begin
      emit_cnt = nbytes;
      emit_data = acc[CODE_W-1:0];
    end
  end

  assign q_pop = out_valid && !out_stall;
  assign q_free = (q_cnt_r == '0) || ((q_cnt_r == QCNT_W'(1)) && !out_stall);
  assign s1_go = s1.valid && ((emit_cnt == '0) || q_free);

  always_comb begin
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt = pend_cnt_r;
    if (s1_go) begin
      if (s1.flush) begin
        pend_bits_nxt = '0;
        pend_cnt_nxt = '0;
      end else begin
        pend_bits_nxt = pend_after;
        pend_cnt_nxt = total[PCNT_W-1:0];
      end
    end
  end

  always_comb begin
    q_data_nxt = q_data_r;
    q_cnt_nxt = q_cnt_r;
    priority if (s1_go && (emit_cnt != '0)) begin
      q_data_nxt = emit_data;
      q_cnt_nxt = emit_cnt;
    end else if (q_pop) begin
      q_data_nxt = q_data_r >> BYTE_W;
      q_cnt_nxt = q_cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r <= '0;
      q_cnt_r <= '0;
    end else begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_data_r <= q_data_nxt;
  end

  assign out_valid = (q_cnt_r != '0);
  assign out_byte = q_data_r[BYTE_W-1:0];
  assign out_last = (q_cnt_r == QCNT_W'(1));

endmodule

`default_nettype wire

### sv/huffman_code_bit_packer.sv
`default_nettype none

// LSB-first Huffman bit packer. A load transaction writes one symbol's code
// and length into a 256-entry table RAM and produces no output. An encode
// transaction reads the table (registered read port), then appends the
// code to the pending bit queue; every completed byte goes out one per
// cycle while out_stall is low, 0 to 4 bytes per encode. A flush gives
// two bytes: the padded remainder byte, then the trailer '8' minus the
// real bit count. Input transactions are taken back to back unless the
// byte queue is busy; the single byte-wide output port is what sets the
// sustained rate. Encoding a symbol never loaded gives undefined bytes.
// out_last marks the final byte of each transaction that gives output.

`include "assert_macros.svh"

module huffman_code_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_req_type,
  input  wire logic [hcbp_pkg::SYM_W-1:0]  in_symbol,
  input  wire logic [hcbp_pkg::CODE_W-1:0] in_code_bits,
  input  wire logic [hcbp_pkg::LEN_W-1:0]  in_code_len,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]      out_byte,
  output logic                             out_last
);

  import hcbp_pkg::*;

  localparam int unsigned CODE_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int unsigned RAM_W = CODE_CAP + LEN_W;

  hcbp_s1_t          s1_r, s1_nxt;
  hcbp_entry_t       entry;
  logic              s1_go;
  logic              in_acc;
  logic              is_load, is_enc, is_flush;
  logic [LEN_W-1:0]  len_cap;
  logic [CODE_CAP-1:0] code_mask;
  logic [RAM_W-1:0]  wr_data;
  logic [RAM_W-1:0]  rd_data;

  assign in_stall = s1_r.valid && !s1_go;
  assign in_acc = in_valid && !in_stall;
  assign is_load = in_acc && (in_req_type == REQ_LOAD);
  assign is_enc = in_acc && (in_req_type == REQ_ENCODE);
  assign is_flush = in_acc && (in_req_type == REQ_FLUSH);

  always_comb begin
    len_cap = (in_code_len > LEN_W'(CODE_CAP)) ? LEN_W'(CODE_CAP) : in_code_len;
    for (int i = 0; i < CODE_CAP; i++) begin
      code_mask[i] = (LEN_W'(i) < len_cap);
    end
    wr_data = {in_code_bits[CODE_CAP-1:0] & code_mask, len_cap};
  end

  hcbp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (is_load),
    .wr_addr (in_symbol),
    .wr_data (wr_data),
    .rd_en   (is_enc),
    .rd_addr (in_symbol),
    .rd_data (rd_data)
  );

  assign entry.code = CODE_W'(rd_data[RAM_W-1:LEN_W]);
  assign entry.len = rd_data[LEN_W-1:0];

  always_comb begin
    s1_nxt = s1_r;
    if (in_acc) begin
      s1_nxt.valid = is_enc || is_flush;
      s1_nxt.flush = is_flush;
    end else if (s1_go) begin
      s1_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else begin
      s1_r <= s1_nxt;
    end
  end

  hcbp_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1        (s1_r),
    .entry     (entry),
    .s1_go     (s1_go),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  `HCBP_ASSERT_NOW(a_stall_only_when_busy, in_stall, s1_r.valid)
  `HCBP_ASSERT_NEXT(a_flush_emits_pair, s1_r.valid && s1_r.flush && s1_go, out_valid && !out_last)
  `HCBP_ASSERT_NEXT(a_more_bytes_follow, out_valid && !out_last && !out_stall, out_valid)

endmodule

`default_nettype wire

### dv/testbench.sv
module testbench;
  import hcbp_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned CODE_CAP = 32;
  localparam int unsigned RANDOM_ITEMS = 185;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 20;

  typedef struct {
    logic [1:0]        req;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    bit                drain;
  } code_req_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_req_type;
  logic [SYM_W-1:0]    in_symbol;
  logic [CODE_W-1:0]   in_code_bits;
  logic [LEN_W-1:0]    in_code_len;
  logic                out_valid;
  logic                out_stall;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last;

  huffman_code_bit_packer #(.MAX_CODE_LEN(CODE_CAP)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_symbol    (in_symbol),
    .in_code_bits (in_code_bits),
    .in_code_len  (in_code_len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  code_req_t    req_pending[$];
  packed_byte_t bytes_expected[$];

  logic [CODE_W-1:0] code_tbl [TABLE_DEPTH];
  logic [LEN_W-1:0]  len_tbl [TABLE_DEPTH];
  logic [PEND_W-1:0] pend_bits;
  logic [PCNT_W-1:0] pend_cnt;

  bit         gen_loaded [TABLE_DEPTH];
  logic [7:0] loaded_syms[$];

  int unsigned error_count;
  int unsigned total_items;
  int unsigned n_accepted;
  int unsigned idle_cycles;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned stall_cyc;
  bit          in_accepted;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic int unsigned clamp_len(input int unsigned l);
    return (l > CODE_CAP) ? CODE_CAP : l;
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] data, input logic last);
    packed_byte_t b;
    b.data = data;
    b.last = last;
    bytes_expected.push_back(b);
  endtask

  task automatic predict_bytes(input code_req_t r);
    int unsigned       ln;
    int unsigned       tot;
    logic [63:0]       mask;
    logic [ACC_W-1:0]  acc;
    case (r.req)
      REQ_LOAD: begin
        ln = clamp_len(r.len);
        mask = (ln == 0) ? 64'd0 : ((64'd1 << ln) - 64'd1);
        code_tbl[r.sym] = r.bits & mask[CODE_W-1:0];
        len_tbl[r.sym] = ln[LEN_W-1:0];
      end
      REQ_ENCODE: begin
        ln = clamp_len(len_tbl[r.sym]);
        acc = {{CODE_W{1'b0}}, pend_bits} | ({{PEND_W{1'b0}}, code_tbl[r.sym]} << pend_cnt);
        tot = pend_cnt + ln;
        while (tot >= 8) begin
          push_byte(acc[7:0], tot < 16);
          acc = acc >> 8;
          tot = tot - 8;
        end
        pend_bits = acc[PEND_W-1:0];
        pend_cnt = tot[PCNT_W-1:0];
      end
      REQ_FLUSH: begin
        push_byte({1'b0, pend_bits}, 1'b0);
        push_byte(ASCII_EIGHT - {5'd0, pend_cnt}, 1'b1);
        pend_bits = '0;
        pend_cnt = '0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic add_req(input logic [1:0] req, input logic [7:0] sym,
                         input logic [31:0] bits, input logic [5:0] len, input bit drain);
    code_req_t r;
    r.req = req;
    r.sym = sym;
    r.bits = bits;
    r.len = len;
    r.drain = drain;
    if (req == REQ_LOAD && !gen_loaded[sym]) begin
      gen_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
    req_pending.push_back(r);
  endtask

  task automatic add_encode(input bit drain);
    add_req(REQ_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
            $urandom, 6'($urandom_range(0, 63)), drain);
  endtask

  function automatic logic [5:0] random_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 6'($urandom_range(1, 12));
    else if (pick < 75) return 6'($urandom_range(13, 32));
    else if (pick < 90) return 6'($urandom_range(33, 63));
    else return 6'd0;
  endfunction

  task automatic build_stimulus();
    int unsigned counted;
    int unsigned pick;
    bit          drain;
    add_req(REQ_LOAD, 8'd0, 32'h0000_0001, 6'd1, 1'b0);
    add_req(REQ_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32, 1'b0);
    add_req(REQ_LOAD, 8'd1, 32'hFFFF_FFFF, 6'd0, 1'b0);
    add_req(REQ_LOAD, 8'd2, 32'hA5A5_A5A5, 6'd63, 1'b0);
    add_req(REQ_LOAD, 8'd3, 32'h1234_5678, 6'd33, 1'b0);
    add_req(REQ_LOAD, 8'd4, 32'hDEAD_BEEF, 6'd5, 1'b0);
    add_req(REQ_LOAD, 8'd5, 32'h0000_00C3, 6'd8, 1'b0);
    add_req(REQ_FLUSH, 8'd0, 32'd0, 6'd0, 1'b0);
    add_req(REQ_ENCODE, 8'd1, 32'd0, 6'd0, 1'b0);
    add_req(REQ_ENCODE, 8'd0, 32'd0, 6'd0, 1'b0);
    add_req(REQ_ENCODE, 8'd4, 32'd0, 6'd0, 1'b0);
    add_req(REQ_ENCODE, 8'd255, 32'd0, 6'd0, 1'b0);
    add_req(REQ_FLUSH, 8'd0, 32'd0, 6'd0, 1'b1);
    add_req(REQ_ENCODE, 8'd5, 32'd0, 6'd0, 1'b0);
    add_req(REQ_ENCODE, 8'd2, 32'd0, 6'd0, 1'b0);
    add_req(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b0);
    add_req(REQ_ENCODE, 8'd3, 32'd0, 6'd0, 1'b0);
    add_req(REQ_FLUSH, 8'd0, 32'd0, 6'd0, 1'b0);
    add_req(REQ_LOAD, 8'd0, 32'hFFFF_FF7F, 6'd7, 1'b0);
    add_req(REQ_ENCODE, 8'd0, 32'd0, 6'd0, 1'b0);
    add_req(REQ_FLUSH, 8'd0, 32'd0, 6'd0, 1'b1);
    add_req(REQ_LOAD, 8'd170, 32'h5555_5555, 6'd42, 1'b0);
    add_req(REQ_ENCODE, 8'd170, 32'd0, 6'd0, 1'b0);
    add_req(REQ_ENCODE, 8'd255, 32'd0, 6'd0, 1'b0);
    add_req(REQ_FLUSH, 8'd0, 32'd0, 6'd0, 1'b0);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      drain = ($urandom_range(0, 99) < 3);
      if (pick < 12) begin
        add_req(REQ_LOAD, 8'($urandom_range(0, 255)), $urandom, random_len(), drain);
        counted++;
      end else if (pick < 83) begin
        add_encode(drain);
        counted++;
      end else if (pick < 95) begin
        add_req(REQ_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                6'($urandom_range(0, 63)), drain);
        counted++;
      end else begin
        add_req(REQ_UNUSED, 8'($urandom_range(0, 255)), $urandom,
                6'($urandom_range(0, 63)), 1'b0);
      end
    end
    add_req(REQ_FLUSH, 8'd0, 32'd0, 6'd0, 1'b0);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // sender: bursts and gaps, holding a stalled transaction
  always @(negedge clk) begin
    code_req_t nxt;
    if (rst_n && !(in_valid && !in_accepted)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_pending.size() == 0 ||
                   (req_pending[0].drain && bytes_expected.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        nxt = req_pending.pop_front();
        in_req_type <= nxt.req;
        in_symbol <= nxt.sym;
        in_code_bits <= nxt.bits;
        in_code_len <= nxt.len;
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 12);
            default: gap_left = $urandom_range(1, 3);
          endcase
        end
      end
    end
  end

  // receiver stall pattern, stepping through four modes in turn
  always @(negedge clk) begin
    stall_cyc++;
    case ((stall_cyc / 400) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 2) != 0);
      default: out_stall <= ((stall_cyc % 5) < 2);
    endcase
  end

  always @(posedge clk) begin
    code_req_t r;
    in_accepted <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      r.req = in_req_type;
      r.sym = in_symbol;
      r.bits = in_code_bits;
      r.len = in_code_len;
      r.drain = 1'b0;
      predict_bytes(r);
      n_accepted++;
    end
  end

  always @(posedge clk) begin
    packed_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (bytes_expected.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", out_byte, out_last));
      end else begin
        want = bytes_expected.pop_front();
        if (out_byte !== want.data)
          report($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
        if (out_last !== want.last)
          report($sformatf("out_last %0b, expected %0b", out_last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("huffman_code_bit_packer test failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_LOAD;
    in_symbol = '0;
    in_code_bits = '0;
    in_code_len = '0;
    out_stall = 1'b0;
    in_accepted = 1'b0;
    pend_bits = '0;
    pend_cnt = '0;
    error_count = 0;
    n_accepted = 0;
    idle_cycles = 0;
    gap_left = 0;
    burst_left = 1;
    stall_cyc = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      code_tbl[i] = '0;
      len_tbl[i] = '0;
      gen_loaded[i] = 1'b0;
    end
    build_stimulus();
    total_items = req_pending.size();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (n_accepted < total_items) @(posedge clk);
    while (bytes_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bytes_expected.size() != 0)
      report($sformatf("%0d expected bytes never arrived", bytes_expected.size()));
    if (error_count == 0) begin
      $display("huffman_code_bit_packer test passed");
    end else begin
      $display("huffman_code_bit_packer test failed");
    end
    $finish;
  end

endmodule
